### design/gsu_pkg.sv
package gsu_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int FRAC_BITS  = 15;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int CONC_W     = 16;
    localparam int CELL_W     = 2 * CONC_W;

    localparam logic [CONC_W-1:0] CONC_ONE = 16'h8000;

    // register indexes on the configuration port
    localparam logic [2:0] REG_DIFF_A   = 3'd0;
    localparam logic [2:0] REG_DIFF_B   = 3'd1;
    localparam logic [2:0] REG_FEED     = 3'd2;
    localparam logic [2:0] REG_KILL     = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_MARGIN_X = 3'd6;
    localparam logic [2:0] REG_MARGIN_Y = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAP,
        ST_MUL,
        ST_DIV,
        ST_SUM
    } gsu_state_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [COL_W-1:0]  addr;
        logic [CELL_W-1:0] cur;
    } gsu_ls_req_t;

endpackage

### design/gsu_line_store.sv
module gsu_line_store
    import gsu_pkg::*;
(
    input  logic              aclk,
    input  gsu_ls_req_t       req,
    output logic [CELL_W-1:0] rd_mid,
    output logic [CELL_W-1:0] rd_top
);

    logic [CELL_W-1:0] mid_mem [MAX_WIDTH];
    logic [CELL_W-1:0] top_mem [MAX_WIDTH];
    logic [CELL_W-1:0] mid_rd_reg;
    logic [CELL_W-1:0] top_rd_reg;

    // read, then write back: the row above moves into the top bank
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            mid_rd_reg <= mid_mem[req.addr];
            top_rd_reg <= top_mem[req.addr];
        end
        if (req.wr_en) begin
            mid_mem[req.addr] <= req.cur;
            top_mem[req.addr] <= mid_rd_reg;
        end
    end

    assign rd_mid = mid_rd_reg;
    assign rd_top = top_rd_reg;

endmodule

### design/gray_scott_stencil_update.sv
// Gray-Scott reaction-diffusion update over a raster stream of cells. Each
// input beat carries one cell (a and b in Q1.15); the block keeps two line
// banks and a 3x3 window and emits, for the cell one row up and one column
// left, the updated concentrations, their deltas and the cell position, but
// only for interior cells inside the margins. Each cell passes through the
// line bank read, Laplacian, diffusion multiply, divide by 5 through a
// reciprocal multiply and final sum states into its result register, and a
// new cell is taken only once the previous one has finished, which waits for
// the output side to be ready; cells outside the interior stop after the
// line bank read.
// Registers must be written while the block is idle.
module gray_scott_stencil_update
    import gsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // conc_a_in[15:0], conc_b_in[31:16]
    input  logic        s_tuser,   // frame_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // conc_a_out, conc_b_out, delta_a, delta_b,
                                   // cell_col, cell_row, zero pad
    output logic        m_tlast,   // last_of_frame

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic [19:0] diff_a_reg, diff_b_reg, feed_reg, kill_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [9:0]  margin_x_reg;
    logic [10:0] margin_y_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_a_reg   <= 20'd65536;
            diff_b_reg   <= 20'd32768;
            feed_reg     <= 20'd3604;
            kill_reg     <= 20'd4063;
            width_reg    <= 12'd1280;
            height_reg   <= 13'd720;
            margin_x_reg <= 10'd1;
            margin_y_reg <= 11'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_DIFF_A:   diff_a_reg   <= pwdata[19:0];
                REG_DIFF_B:   diff_b_reg   <= pwdata[19:0];
                REG_FEED:     feed_reg     <= pwdata[19:0];
                REG_KILL:     kill_reg     <= pwdata[19:0];
                REG_WIDTH:    width_reg    <= pwdata[11:0];
                REG_HEIGHT:   height_reg   <= pwdata[12:0];
                REG_MARGIN_X: margin_x_reg <= pwdata[9:0];
                REG_MARGIN_Y: margin_y_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_DIFF_A:   prdata = 32'(diff_a_reg);
            REG_DIFF_B:   prdata = 32'(diff_b_reg);
            REG_FEED:     prdata = 32'(feed_reg);
            REG_KILL:     prdata = 32'(kill_reg);
            REG_WIDTH:    prdata = 32'(width_reg);
            REG_HEIGHT:   prdata = 32'(height_reg);
            REG_MARGIN_X: prdata = 32'(margin_x_reg);
            REG_MARGIN_Y: prdata = 32'(margin_y_reg);
            default:      prdata = 32'd0;
        endcase
    end

    // control
    gsu_state_t  state_reg, state_next;
    logic        accept;
    logic        out_free;
    logic        out_load;
    gsu_ls_req_t ls_req;
    logic [CELL_W-1:0] rd_mid, rd_top;

    logic             interior_reg, last_reg;
    logic [COL_W-1:0] col_reg, col_cnt_reg;
    logic [ROW_W-1:0] row_reg, row_cnt_reg;
    logic [CELL_W-1:0] cur_reg;

    logic m_tvalid_reg;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_READ;
            ST_READ: state_next = interior_reg ? ST_LAP : ST_IDLE;
            ST_LAP:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_SUM;
            ST_SUM:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic [COL_W-1:0] col_cur;

    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        out_load      = (state_reg == ST_SUM) && out_free;
        ls_req.rd_en  = (state_reg == ST_IDLE) && s_tvalid;
        ls_req.wr_en  = (state_reg == ST_READ);
        ls_req.addr   = (state_reg == ST_READ) ? col_reg : col_cur;
        ls_req.cur    = cur_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    gsu_line_store u_line_store (
        .aclk   (aclk),
        .req    (ls_req),
        .rd_mid (rd_mid),
        .rd_top (rd_top)
    );

    // position of the incoming cell
    logic [11:0] w_eff;
    logic [12:0] h_eff;
    logic [11:0] col_pre, col_inc;
    logic [12:0] row_pre, row_inc;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_cnt_next;
    logic [ROW_W-1:0] row_cnt_next;
    logic [13:0] c14, r14, mx14, my14;
    logic        interior_cur, last_cur;
    logic [CONC_W-1:0] a_in, b_in;

    always_comb begin
        w_eff = (width_reg == 12'd0) ? 12'd1 :
                (width_reg > 12'd2048) ? 12'd2048 : width_reg;
        h_eff = (height_reg == 13'd0) ? 13'd1 :
                (height_reg > 13'd4096) ? 13'd4096 : height_reg;
        col_pre = s_tuser ? 12'd0 : {1'b0, col_cnt_reg};
        row_pre = s_tuser ? 13'd0 : {1'b0, row_cnt_reg};
        if (col_pre >= w_eff) begin
            col_pre = 12'd0;
            row_pre = row_pre + 13'd1;
        end
        if (row_pre >= h_eff) row_pre = 13'd0;
        col_cur = col_pre[COL_W-1:0];
        row_cur = row_pre[ROW_W-1:0];

        col_inc      = {1'b0, col_cur} + 12'd1;
        row_inc      = {1'b0, row_cur};
        col_cnt_next = col_inc[COL_W-1:0];
        if (col_inc >= w_eff) begin
            col_cnt_next = '0;
            row_inc      = row_inc + 13'd1;
            if (row_inc >= h_eff) row_inc = 13'd0;
        end
        row_cnt_next = row_inc[ROW_W-1:0];

        c14  = 14'(col_cur);
        r14  = 14'(row_cur);
        mx14 = 14'(margin_x_reg);
        my14 = 14'(margin_y_reg);
        interior_cur = (c14 >= mx14 + 14'd2) && (c14 + mx14 < 14'(w_eff)) &&
                       (r14 >= my14 + 14'd2) && (r14 + my14 < 14'(h_eff));
        last_cur = (c14 + mx14 + 14'd1 == 14'(w_eff)) &&
                   (r14 + my14 + 14'd1 == 14'(h_eff));

        a_in = (s_tdata[15:0]  > CONC_ONE) ? CONC_ONE : s_tdata[15:0];
        b_in = (s_tdata[31:16] > CONC_ONE) ? CONC_ONE : s_tdata[31:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            interior_reg <= 1'b0;
        end else if (accept) begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            interior_reg <= interior_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg  <= col_cur;
            row_reg  <= row_cur;
            last_reg <= last_cur;
            cur_reg  <= {b_in, a_in};
        end
    end

    // 3x3 window: row 0 top, row 2 current; column 2 newest
    logic [CELL_W-1:0] win_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    win_reg[r][k] <= '0;
        end else if (state_reg == ST_READ) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_top;
            win_reg[1][2] <= rd_mid;
            win_reg[2][2] <= cur_reg;
        end
    end

    function automatic logic signed [20:0] lap_sum(input logic [CELL_W-1:0] w [3][3],
                                                   input logic hi);
        logic [17:0] e, c;
        logic signed [22:0] s;
        e = 18'(hi ? w[0][1][31:16] : w[0][1][15:0]) +
            18'(hi ? w[2][1][31:16] : w[2][1][15:0]) +
            18'(hi ? w[1][0][31:16] : w[1][0][15:0]) +
            18'(hi ? w[1][2][31:16] : w[1][2][15:0]);
        c = 18'(hi ? w[0][0][31:16] : w[0][0][15:0]) +
            18'(hi ? w[0][2][31:16] : w[0][2][15:0]) +
            18'(hi ? w[2][0][31:16] : w[2][0][15:0]) +
            18'(hi ? w[2][2][31:16] : w[2][2][15:0]);
        s = $signed({3'b000, e, 2'b00}) + $signed({5'b00000, c}) -
            $signed(23'(hi ? w[1][1][31:16] : w[1][1][15:0]) * 23'd20);
        return s[20:0];
    endfunction

    // Laplacian stage
    logic signed [20:0] sa_reg, sb_reg;
    logic [CONC_W-1:0]  ca_reg, cb_reg, ab_reg;
    logic [19:0]        fa_reg;
    logic [20:0]        kb_reg;
    logic               flat_reg;

    logic signed [20:0] sa_c, sb_c;
    logic [CONC_W-1:0]  ca_c, cb_c;
    logic [32:0]        ab_p;
    logic [36:0]        fa_p;
    logic [37:0]        kb_p;

    always_comb begin
        sa_c = lap_sum(win_reg, 1'b0);
        sb_c = lap_sum(win_reg, 1'b1);
        ca_c = win_reg[1][1][15:0];
        cb_c = win_reg[1][1][31:16];
        ab_p = 33'(ca_c) * 33'(cb_c) + 33'd16384;
        fa_p = 37'(feed_reg) * 37'(CONC_ONE - ca_c) + 37'd32768;
        kb_p = (38'(kill_reg) + 38'(feed_reg)) * 38'(cb_c) + 38'd32768;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LAP) begin
            sa_reg   <= sa_c;
            sb_reg   <= sb_c;
            ca_reg   <= ca_c;
            cb_reg   <= cb_c;
            ab_reg   <= ab_p[30:15];
            fa_reg   <= fa_p[35:16];
            kb_reg   <= kb_p[36:16];
            flat_reg <= (22'(sa_c) + 22'(sb_c)) == 22'd0;
        end
    end

    // diffusion multiply, floor of (dA*S + 20*2^15) / 2^18, and p
    logic signed [23:0] ua_reg, ub_reg;
    logic [CONC_W-1:0]  p_reg;
    logic signed [41:0] pa_sum, pb_sum;
    logic [32:0]        p_p;

    always_comb begin
        pa_sum = $signed({1'b0, diff_a_reg}) * sa_reg + 42'sd655360;
        pb_sum = $signed({1'b0, diff_b_reg}) * sb_reg + 42'sd655360;
        p_p    = 33'(ab_reg) * 33'(cb_reg) + 33'd16384;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            ua_reg <= pa_sum[41:18];
            ub_reg <= pb_sum[41:18];
            p_reg  <= p_p[30:15];
        end
    end

    // floor division by 5 on an offset, non-negative value
    localparam logic [25:0] RECIP5   = 26'd53687092;
    localparam logic [25:0] DIV_OFS  = 26'd20971520;
    logic signed [23:0] ta_reg, tb_reg;
    logic [25:0]        va, vb;
    logic [50:0]        qa_p, qb_p;

    always_comb begin
        va   = 26'($signed({{2{ua_reg[23]}}, ua_reg}) + $signed(DIV_OFS));
        vb   = 26'($signed({{2{ub_reg[23]}}, ub_reg}) + $signed(DIV_OFS));
        qa_p = 51'(va[24:0]) * 51'(RECIP5);
        qb_p = 51'(vb[24:0]) * 51'(RECIP5);
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV) begin
            ta_reg <= $signed({1'b0, qa_p[50:28]}) - 24'sd4194304;
            tb_reg <= $signed({1'b0, qb_p[50:28]}) - 24'sd4194304;
        end
    end

    // final sums, clamps and result register
    logic signed [25:0] da, db, na_s, nb_s;
    logic [CONC_W-1:0]  na, nb;
    logic [19:0]        da_f, db_f;

    always_comb begin
        da = 26'(ta_reg) - $signed({10'd0, p_reg}) + $signed({6'd0, fa_reg});
        db = 26'(tb_reg) + $signed({10'd0, p_reg}) - $signed({5'd0, kb_reg});
        na_s = $signed({10'd0, ca_reg}) + da;
        nb_s = $signed({10'd0, cb_reg}) + db;
        na = (na_s < 0) ? '0 : (na_s > $signed(26'(CONC_ONE))) ? CONC_ONE : na_s[15:0];
        nb = (nb_s < 0) ? '0 : (nb_s > $signed(26'(CONC_ONE))) ? CONC_ONE : nb_s[15:0];
        da_f = (da > 26'sd524287) ? 20'h7FFFF : (da < -26'sd524288) ? 20'h80000 : da[19:0];
        db_f = (db > 26'sd524287) ? 20'h7FFFF : (db < -26'sd524288) ? 20'h80000 : db[19:0];
        if (flat_reg) begin
            na   = ca_reg;
            nb   = cb_reg;
            da_f = '0;
            db_f = '0;
        end
    end

    logic [95:0] m_data_reg;
    logic        m_last_reg;
    logic        m_tvalid_next;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;

    assign out_col = col_reg - COL_W'(1);
    assign out_row = row_reg - ROW_W'(1);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)      m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else          m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {1'b0, out_row, out_col, db_f, da_f, nb, na};
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### design/gsu_checker.sv
module gsu_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second cell taken while one is in flight");

    a_conc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= 16'h8000) && (m_tdata[31:16] <= 16'h8000))
        else $error("concentration above one");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind gray_scott_stencil_update gsu_port_checker u_gsu_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
